// ----- design/sbb_pkg.sv -----
// ----------------------------------------------------------------------------
// sbb_pkg: shared types and constants of the separable 3x3 box blur
// Sizes, register indexes, line store entry layout and result slot types.
// ----------------------------------------------------------------------------
package sbb_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;

   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int COST_W       = 8;
   localparam int HSUM_W       = 10;     // sum of three costs
   localparam int TOTAL_W      = 12;     // sum of three horizontal sums
   localparam int BLUR_W       = 8;

   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam int RSP_DATA_W   = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 1'd1;

   // result slots of one item, in emission order
   localparam int SLOT_N       = 4;
   localparam int SLOT_IDX_W   = $clog2(SLOT_N);
   localparam int SLOT_LEFT_ABOVE  = 0;   // left column, row above
   localparam int SLOT_LEFT_LAST   = 1;   // left column, last row
   localparam int SLOT_RIGHT_ABOVE = 2;   // row-end column, row above
   localparam int SLOT_RIGHT_LAST  = 3;   // row-end column, last row

   typedef struct packed {
      logic [HSUM_W-1:0] older_sum;
      logic [HSUM_W-1:0] prev_sum;
   } line_entry_type;

   typedef struct packed {
      logic           en;
      logic [COL_W-1:0] addr;
      line_entry_type data;
   } line_write_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [COST_W-1:0] prior;
      logic [COST_W-1:0] second_prior;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic              end_row;
      logic              last_row;
   } stage_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [COL_W-1:0]   column;
      logic [ROW_W-1:0]   row;
      logic               last;
   } result_type;

   typedef struct packed {
      result_type [SLOT_N-1:0] slot;
      logic [SLOT_N-1:0]       mask;
   } result_set_type;

endpackage

// ----- design/sbb_line_store.sv -----
// ----------------------------------------------------------------------------
// sbb_line_store: line store of horizontal sums
// One entry per column holds the sums of the two rows above. One write port,
// two registered read ports; a read of the address being written returns the
// new data.
// ----------------------------------------------------------------------------
module sbb_line_store
   import sbb_pkg::*;
(
   input  logic             clock,
   input  line_write_type   wr,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr_a,
   input  logic [COL_W-1:0] rd_addr_b,
   output line_entry_type   rd_data_a,
   output line_entry_type   rd_data_b
);

   line_entry_type line_mem_ff [MAX_WIDTH];
   line_entry_type rd_a_ff;
   line_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr.en && (wr.addr == rd_addr_a)) ? wr.data : line_mem_ff[rd_addr_a];
         rd_b_ff <= (wr.en && (wr.addr == rd_addr_b)) ? wr.data : line_mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- design/sbb_stencil.sv -----
// ----------------------------------------------------------------------------
// sbb_stencil: horizontal and vertical sums of one item
// Forms up to two horizontal sums (left column, and the row-end column),
// the 3x3 totals they complete, and the line store updates.
// ----------------------------------------------------------------------------
module sbb_stencil
   import sbb_pkg::*;
(
   input  stage_type      stage,
   input  line_entry_type rd_left,
   input  line_entry_type rd_right,
   output result_set_type results,
   output line_write_type wr_first,
   output line_write_type wr_second
);

   logic               has_left;
   logic [COST_W-1:0]  left_l;
   logic [COST_W-1:0]  left_r;
   logic [HSUM_W-1:0]  hsum_l;
   logic [HSUM_W-1:0]  hsum_r;
   logic [HSUM_W-1:0]  older_l;
   logic [HSUM_W-1:0]  older_r;
   logic [HSUM_W-1:0]  above_l;
   logic [HSUM_W-1:0]  above_r;
   logic               row_zero;
   logic [COL_W-1:0]   col_l;
   logic [ROW_W-1:0]   row_up;
   line_write_type     wr_l;
   line_write_type     wr_r;

   always_comb begin
      has_left = (stage.column != '0);
      row_zero = (stage.row == '0);
      col_l    = COL_W'(stage.column - COL_W'(1));
      row_up   = ROW_W'(stage.row - ROW_W'(1));

      // clamp at the row start: repeat the first cell
      left_l = (stage.column >= COL_W'(2)) ? stage.second_prior : stage.prior;
      left_r = has_left ? stage.prior : stage.cost;
      hsum_l = HSUM_W'(left_l) + HSUM_W'(stage.prior) + HSUM_W'(stage.cost);
      hsum_r = HSUM_W'(left_r) + HSUM_W'({stage.cost, 1'b0});

      // second row: the top row stands in for the row two above
      older_l = (stage.row == ROW_W'(1)) ? rd_left.prev_sum  : rd_left.older_sum;
      older_r = (stage.row == ROW_W'(1)) ? rd_right.prev_sum : rd_right.older_sum;
      above_l = row_zero ? hsum_l : rd_left.prev_sum;
      above_r = row_zero ? hsum_r : rd_right.prev_sum;

      results = '0;
      results.mask[SLOT_LEFT_ABOVE]  = has_left && !row_zero;
      results.mask[SLOT_LEFT_LAST]   = has_left && stage.last_row;
      results.mask[SLOT_RIGHT_ABOVE] = stage.end_row && !row_zero;
      results.mask[SLOT_RIGHT_LAST]  = stage.end_row && stage.last_row;

      results.slot[SLOT_LEFT_ABOVE].total  = TOTAL_W'(older_l) +
         TOTAL_W'(rd_left.prev_sum) + TOTAL_W'(hsum_l);
      results.slot[SLOT_LEFT_ABOVE].column = col_l;
      results.slot[SLOT_LEFT_ABOVE].row    = row_up;
      results.slot[SLOT_LEFT_ABOVE].last   = 1'b0;

      // bottom edge: this row counted twice
      results.slot[SLOT_LEFT_LAST].total  = TOTAL_W'(above_l) + TOTAL_W'({hsum_l, 1'b0});
      results.slot[SLOT_LEFT_LAST].column = col_l;
      results.slot[SLOT_LEFT_LAST].row    = stage.row;
      results.slot[SLOT_LEFT_LAST].last   = 1'b0;

      results.slot[SLOT_RIGHT_ABOVE].total  = TOTAL_W'(older_r) +
         TOTAL_W'(rd_right.prev_sum) + TOTAL_W'(hsum_r);
      results.slot[SLOT_RIGHT_ABOVE].column = stage.column;
      results.slot[SLOT_RIGHT_ABOVE].row    = row_up;
      results.slot[SLOT_RIGHT_ABOVE].last   = 1'b0;

      results.slot[SLOT_RIGHT_LAST].total  = TOTAL_W'(above_r) + TOTAL_W'({hsum_r, 1'b0});
      results.slot[SLOT_RIGHT_LAST].column = stage.column;
      results.slot[SLOT_RIGHT_LAST].row    = stage.row;
      results.slot[SLOT_RIGHT_LAST].last   = stage.last_row;

      // shift the column's sums down one row
      wr_l.en             = has_left;
      wr_l.addr           = col_l;
      wr_l.data.older_sum = rd_left.prev_sum;
      wr_l.data.prev_sum  = hsum_l;
      wr_r.en             = stage.end_row;
      wr_r.addr           = stage.column;
      wr_r.data.older_sum = rd_right.prev_sum;
      wr_r.data.prev_sum  = hsum_r;

      if (has_left) begin
         wr_first  = wr_l;
         wr_second = wr_r;
      end else begin
         wr_first  = wr_r;
         wr_second = '0;
      end
   end

endmodule

// ----- design/sbb_result_queue.sv -----
// ----------------------------------------------------------------------------
// sbb_result_queue: result slots and output beat
// Holds the results of one item and sends them in slot order, one beat per
// cycle while the output is ready, dividing each total by nine on the way out.
// ----------------------------------------------------------------------------
module sbb_result_queue
   import sbb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  result_set_type        load_set,
   output logic                  free,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [RSP_DATA_W-1:0] out_data,
   output logic                  out_last
);

   localparam int PAD_W      = RSP_DATA_W - BLUR_W - COL_W - ROW_W;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W     = RECIP_SHIFT + BLUR_W;
   // ceil(2^16 / 9); exact for totals up to 2295
   localparam logic [PROD_W-1:0] DIV9_RECIP = PROD_W'(7282);

   result_type [SLOT_N-1:0] slot_ff;
   logic [SLOT_N-1:0]       mask_ff;
   logic [SLOT_N-1:0]       mask_in;
   logic [SLOT_IDX_W-1:0]   sel;
   logic                    take;
   logic                    single;
   result_type              cur;
   logic [PROD_W-1:0]       prod;

   always_comb begin
      sel = '0;
      for (int i = SLOT_N - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = SLOT_IDX_W'(i);
         end
      end
   end

   assign out_valid = (mask_ff != '0);
   assign take      = out_valid && out_ready;
   assign single    = ((mask_ff & (mask_ff - SLOT_N'(1))) == '0);
   assign free      = !out_valid || (single && out_ready);

   always_comb begin
      if (load) begin
         mask_in = load_set.mask;
      end else if (take) begin
         mask_in = mask_ff & ~(SLOT_N'(1) << sel);
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= load_set.slot;
      end
   end

   assign cur      = slot_ff[sel];
   assign prod     = PROD_W'(cur.total) * DIV9_RECIP;
   assign out_data = {{PAD_W{1'b0}}, cur.row, cur.column, prod[PROD_W-1:RECIP_SHIFT]};
   assign out_last = cur.last;

endmodule

// ----- design/separable_box_blur_3x3_core.sv -----
// ----------------------------------------------------------------------------
// separable_box_blur_3x3_core: streaming 3x3 box blur of a cost grid
// Path: an accepted cell enters the input stage register, then the result queue.
// Throughput: one cell per cycle while each cell yields at most one result and
//   the output is ready; a cell yielding more results holds the input until its
//   last beat is taken, and no cell directly follows a two-write row-end cell.
// Reset: counters, handshake state and sizes (1 x 1) are cleared;
//   the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module separable_box_blur_3x3_core
   import sbb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [COST_W-1:0]      req_tdata,   // [7:0] cell_cost

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] blurred_cost, [17:8] out_column,
                                               // [29:18] out_row, [31:30] zero
   output logic                   rsp_tlast,   // frame_last

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // ------------------------------------------------------------------
   // Configuration: kept as index of the last column / last row, with a
   // zero size read as one and an oversize saturated.
   // ------------------------------------------------------------------
   logic [COL_W-1:0]        width_last_ff;
   logic [COL_W-1:0]        width_last_in;
   logic [ROW_W-1:0]        height_last_ff;
   logic [ROW_W-1:0]        height_last_in;
   logic [CFG_WIDTH_W-1:0]  cfg_width;
   logic [CFG_HEIGHT_W-1:0] cfg_height;
   logic                    csr_write;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign cfg_width  = csr_data[CFG_WIDTH_W-1:0];
   assign cfg_height = csr_data[CFG_HEIGHT_W-1:0];

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GRID_WIDTH: begin
               if (cfg_width == '0) begin
                  width_last_in = '0;
               end else if (cfg_width > CFG_WIDTH_W'(MAX_WIDTH)) begin
                  width_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  width_last_in = COL_W'(cfg_width - CFG_WIDTH_W'(1));
               end
            end
            CSR_GRID_HEIGHT: begin
               if (cfg_height == '0) begin
                  height_last_in = '0;
               end else if (cfg_height > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
                  height_last_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  height_last_in = ROW_W'(cfg_height - CFG_HEIGHT_W'(1));
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Raster position and the two previous cells, advanced per input beat
   // ------------------------------------------------------------------
   logic [COL_W-1:0]  column_ff;
   logic [COL_W-1:0]  column_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [COST_W-1:0] prior_ff;
   logic [COST_W-1:0] prior_in;
   logic [COST_W-1:0] second_prior_ff;
   logic [COST_W-1:0] second_prior_in;
   logic              end_row;
   logic              last_row;
   logic              req_accept;

   assign end_row    = (column_ff >= width_last_ff);
   assign last_row   = (row_ff >= height_last_ff);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      column_in       = column_ff;
      row_in          = row_ff;
      prior_in        = prior_ff;
      second_prior_in = second_prior_ff;
      if (req_accept) begin
         second_prior_in = prior_ff;
         prior_in        = req_tdata;
         if (end_row) begin
            column_in = '0;
            row_in    = last_row ? '0 : ROW_W'(row_ff + ROW_W'(1));
         end else begin
            column_in = COL_W'(column_ff + COL_W'(1));
         end
      end
   end

   // ------------------------------------------------------------------
   // Input stage register; line store reads launch on the same edge
   // ------------------------------------------------------------------
   stage_type      s1_ff;
   stage_type      s1_in;
   logic           s1_valid_ff;
   logic           s1_valid_in;
   logic           s1_adv;
   logic           s1_dual;
   logic           q_free;
   line_entry_type rd_left;
   line_entry_type rd_right;
   result_set_type results;
   line_write_type wr_first;
   line_write_type wr_second;
   line_write_type deferred_ff;
   line_write_type deferred_in;
   line_write_type mem_wr;

   always_comb begin
      s1_in.cost         = req_tdata;
      s1_in.prior        = prior_ff;
      s1_in.second_prior = second_prior_ff;
      s1_in.column       = column_ff;
      s1_in.row          = row_ff;
      s1_in.end_row      = end_row;
      s1_in.last_row     = last_row;
   end

   // a row-end cell past column 0 writes two line store entries; the second
   // write is registered and goes out in the cycle after, so no new cell may follow it directly
   assign s1_dual     = s1_ff.end_row && (s1_ff.column != '0);
   assign s1_adv      = s1_valid_ff && q_free;
   assign req_tready  = (!s1_valid_ff || q_free) && !(s1_valid_ff && s1_dual);
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);

   always_comb begin
      deferred_in    = wr_second;
      deferred_in.en = s1_adv && wr_second.en;
      if (deferred_ff.en) begin
         mem_wr = deferred_ff;
      end else if (s1_adv) begin
         mem_wr = wr_first;
      end else begin
         mem_wr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff   <= '0;
         height_last_ff  <= '0;
         column_ff       <= '0;
         row_ff          <= '0;
         prior_ff        <= '0;
         second_prior_ff <= '0;
         s1_valid_ff     <= 1'b0;
         deferred_ff.en  <= 1'b0;
      end else begin
         width_last_ff   <= width_last_in;
         height_last_ff  <= height_last_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
         prior_ff        <= prior_in;
         second_prior_ff <= second_prior_in;
         s1_valid_ff     <= s1_valid_in;
         deferred_ff     <= deferred_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   // left column is x-1, row-end column is x
   sbb_line_store u_line_store (
      .clock     (clock),
      .wr        (mem_wr),
      .rd_en     (req_accept),
      .rd_addr_a (COL_W'(column_ff - COL_W'(1))),
      .rd_addr_b (column_ff),
      .rd_data_a (rd_left),
      .rd_data_b (rd_right)
   );

   sbb_stencil u_stencil (
      .stage     (s1_ff),
      .rd_left   (rd_left),
      .rd_right  (rd_right),
      .results   (results),
      .wr_first  (wr_first),
      .wr_second (wr_second)
   );

   // ------------------------------------------------------------------
   // Result slots and output beat
   // ------------------------------------------------------------------
   sbb_result_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_adv),
      .load_set  (results),
      .free      (q_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // the late second write never meets a write from the input stage
   assert property (@(posedge clock) disable iff (reset)
      deferred_ff.en |-> !s1_adv)
      else $error("late line store write collides with stage write");

   // the late second write drains at once and is never held over
   assert property (@(posedge clock) disable iff (reset)
      deferred_ff.en |=> !deferred_ff.en)
      else $error("late line store write held more than one cycle");

   // no beat enters behind a row-end cell with two writes
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_dual) |-> !req_accept)
      else $error("input beat accepted behind a two-write row end");

endmodule
